FILE: src/dmd_pkg.sv
// Package for the decimal fixed-point multiply/divide block.
// Holds status codes, widths and the struct handed down the divider chain.
package dmd_pkg;

  localparam int unsigned QW = 33;  // quotient bits, remainder width
  localparam logic [31:0] SCALE = 32'd10000;
  localparam logic [63:0] HALF_SCALE = 64'd5000;
  localparam logic [32:0] POS_LIMIT = 33'h0_7FFF_FFFF;
  localparam logic [32:0] NEG_LIMIT = 33'h0_8000_0000;

  localparam logic OP_MUL = 1'b0;
  localparam logic OP_DIV = 1'b1;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_DIV_ZERO = 2'd2
  } status_t;

  // One in-flight item inside the divider chain.
  typedef struct packed {
    logic          op;
    logic          neg;
    logic          ma_nz;
    logic          ovf;
    logic          dz;
    logic [QW-1:0] d;
    logic [QW-1:0] r;
    logic [QW-1:0] n;
    logic [QW-1:0] q;
  } cell_t;

endpackage

FILE: src/dmd_if.sv
// Channel interfaces for operands and results.
// Depends on nothing; payload fields follow the block's item layout.
interface dmd_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;
  modport source (output valid, req_type, operand_a, operand_b, input ready);
  modport sink   (input valid, req_type, operand_a, operand_b, output ready);
endinterface

interface dmd_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] result_value;
  logic [1:0]         status;
  modport source (output valid, result_value, status, input ready);
  modport sink   (input valid, result_value, status, output ready);
endinterface

FILE: src/dmd_front.sv
// Front end: magnitudes, one shared 32x32 multiplier, dividend/divisor setup.
// Depends on dmd_pkg. Three register stages, all advancing on en.
module dmd_front import dmd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic        in_op,
  input  logic [31:0] in_a,
  input  logic [31:0] in_b,
  output logic        out_vld,
  output cell_t       out_cell
);

  // stage A
  logic        a_vld_r;
  logic        a_op_r, a_neg_r, a_dz_r, a_nz_r;
  logic [31:0] a_ma_r, a_mb_r;
  // stage B
  logic        b_vld_r;
  logic        b_op_r, b_neg_r, b_dz_r, b_nz_r;
  logic [63:0] b_prod_r;
  logic [QW-1:0] b_d_r;
  // stage C
  logic        c_vld_r;
  cell_t       c_cell_r;

  logic [31:0] ma_nxt, mb_nxt, mul_b;
  logic [63:0] num;

  always_comb begin
    ma_nxt = in_a[31] ? (32'd0 - in_a) : in_a;
    mb_nxt = in_b[31] ? (32'd0 - in_b) : in_b;
    mul_b  = (a_op_r == OP_DIV) ? SCALE : a_mb_r;
    num    = b_prod_r + ((b_op_r == OP_DIV) ? 64'd0 : HALF_SCALE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
      c_vld_r <= 1'b0;
    end else if (en) begin
      a_vld_r <= in_vld;
      b_vld_r <= a_vld_r;
      c_vld_r <= b_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_op_r  <= in_op;
      a_neg_r <= in_a[31] ^ in_b[31];
      a_dz_r  <= (in_op == OP_DIV) && (in_b == 32'd0);
      a_nz_r  <= (in_a != 32'd0);
      a_ma_r  <= ma_nxt;
      a_mb_r  <= mb_nxt;

      b_op_r   <= a_op_r;
      b_neg_r  <= a_neg_r;
      b_dz_r   <= a_dz_r;
      b_nz_r   <= a_nz_r;
      b_prod_r <= a_ma_r * mul_b;
      b_d_r    <= (a_op_r == OP_DIV) ? {1'b0, a_mb_r} : {1'b0, SCALE};

      c_cell_r.op    <= b_op_r;
      c_cell_r.neg   <= b_neg_r;
      c_cell_r.dz    <= b_dz_r;
      c_cell_r.ma_nz <= b_nz_r;
      c_cell_r.d     <= b_d_r;
      // quotient of 2^33 or more is out of range anyway
      c_cell_r.ovf   <= ({2'b00, num[63:QW]} >= b_d_r);
      c_cell_r.r     <= {2'b00, num[63:QW]};
      c_cell_r.n     <= num[QW-1:0];
      c_cell_r.q     <= '0;
    end
  end

  assign out_vld  = c_vld_r;
  assign out_cell = c_cell_r;

endmodule

FILE: src/dmd_div_cell.sv
// One restoring-division cell: brings in one dividend bit, makes one quotient bit.
// Depends on dmd_pkg.
module dmd_div_cell import dmd_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  en,
  input  logic  in_vld,
  input  cell_t in_cell,
  output logic  out_vld,
  output cell_t out_cell
);

  logic    vld_r;
  cell_t   cell_r, cell_nxt;
  logic [QW:0] trial;
  logic        take;

  always_comb begin
    cell_nxt = in_cell;
    trial    = {in_cell.r, in_cell.n[QW-1]};
    take     = (trial >= {1'b0, in_cell.d});
    cell_nxt.r = take ? QW'(trial - {1'b0, in_cell.d}) : trial[QW-1:0];
    cell_nxt.n = {in_cell.n[QW-2:0], 1'b0};
    cell_nxt.q = {in_cell.q[QW-2:0], take};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (en) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cell_r <= cell_nxt;
    end
  end

  assign out_vld  = vld_r;
  assign out_cell = cell_r;

endmodule

FILE: src/decimal_fixed_point_mul_div.sv
// Decimal fixed-point (scale 10000) multiply/divide, top level.
// Depends on dmd_pkg, dmd_if, dmd_front and dmd_div_cell.
// A new beat is taken every cycle unless stalled; each accepted operand pair
// passes through three front stages (magnitudes, one shared 32x32
// multiplier, rounding offset), a chain of 33 division cells that each
// produce one quotient bit, and an output register that rounds and packs.
// The whole pipeline stalls only while a finished result waits on out_ch.
module decimal_fixed_point_mul_div import dmd_pkg::*; (
  input logic clk,
  input logic rst_n,
  dmd_in_if.sink    in_ch,
  dmd_out_if.source out_ch
);

  logic en;
  logic  vld_w  [QW+1];
  cell_t cell_w [QW+1];

  logic        out_vld_r;
  logic [31:0] out_val_r;
  status_t     out_st_r;

  assign en          = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  dmd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (in_ch.valid),
    .in_op    (in_ch.req_type),
    .in_a     (in_ch.operand_a),
    .in_b     (in_ch.operand_b),
    .out_vld  (vld_w[0]),
    .out_cell (cell_w[0])
  );

  for (genvar i = 0; i < QW; i++) begin : g_cell
    dmd_div_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .in_vld   (vld_w[i]),
      .in_cell  (cell_w[i]),
      .out_vld  (vld_w[i+1]),
      .out_cell (cell_w[i+1])
    );
  end

  cell_t       fin;
  logic        rnd;
  logic [QW:0] qr;
  logic [32:0] lim;
  logic [31:0] val_nxt;
  status_t     st_nxt;

  always_comb begin
    fin = cell_w[QW];
    rnd = (fin.op == OP_DIV) && fin.ma_nz && ({fin.r, 1'b0} >= {1'b0, fin.d});
    qr  = {1'b0, fin.q} + {{QW{1'b0}}, rnd};
    lim = fin.neg ? NEG_LIMIT : POS_LIMIT;
    if (fin.dz) begin
      st_nxt  = ST_DIV_ZERO;
      val_nxt = '0;
    end else if (fin.ovf || (qr > {1'b0, lim})) begin
      st_nxt  = ST_OVERFLOW;
      val_nxt = '0;
    end else begin
      st_nxt  = ST_OK;
      val_nxt = fin.neg ? (32'd0 - qr[31:0]) : qr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vld_w[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_val_r <= val_nxt;
      out_st_r  <= st_nxt;
    end
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.result_value = out_val_r;
  assign out_ch.status       = out_st_r;

endmodule

FILE: src/dmd_checker.sv
// Port-level checks for decimal_fixed_point_mul_div, bound to the top level.
// Depends on dmd_pkg.
module dmd_checker import dmd_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] out_result,
  input logic [1:0]  out_status
);

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_result) && $stable(out_status))
    else $error("result beat changed while stalled");

  a_fault_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_result == 32'd0)
    else $error("faulted result not zero");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status == ST_OK || out_status == ST_OVERFLOW
                  || out_status == ST_DIV_ZERO)
    else $error("bad status code");

  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output");

endmodule

bind decimal_fixed_point_mul_div dmd_checker u_dmd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_result (out_ch.result_value),
  .out_status (out_ch.status)
);
